### hw/rtl/tbt_pkg.sv
// shared types and constants of the closest-key trie lookup block
`default_nettype none
package tbt_pkg;

   localparam int NODE_DEPTH_DEF = 4096;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int CNT_W  = 13;
   localparam int HGT_W  = 6;
   localparam int STAT_W = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_WALK,
      ST_NEAR,
      ST_SCAN,
      ST_SPLIT,
      ST_ATTACH,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/tbt_if.sv
// request and response channel interfaces of the trie lookup block
`default_nettype none
interface tbt_req_if #(
   parameter int KEY_BITS   = tbt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = tbt_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output req_type, output key, output value, input ready);
   modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface tbt_rsp_if #(
   parameter int KEY_BITS   = tbt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = tbt_pkg::VALUE_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic [tbt_pkg::STAT_W-1:0] status;
   logic [KEY_BITS-1:0]        found_key;
   logic [VALUE_BITS-1:0]      found_value;
   logic [tbt_pkg::CNT_W-1:0]  entry_count;
   logic [tbt_pkg::CNT_W-1:0]  internal_count;
   logic [tbt_pkg::HGT_W-1:0]  tree_height;

   modport source (output valid, output status, output found_key, output found_value,
                   output entry_count, output internal_count, output tree_height,
                   input ready);
   modport sink   (input valid, input status, input found_key, input found_value,
                   input entry_count, input internal_count, input tree_height,
                   output ready);
endinterface
`default_nettype wire

### hw/rtl/tbt_mem.sv
// node memory: child links, leaf keys and leaf values, one write and one read port
`default_nettype none
module tbt_mem #(
   parameter int NODE_DEPTH = tbt_pkg::NODE_DEPTH_DEF,
   parameter int KEY_BITS   = tbt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = tbt_pkg::VALUE_BITS_DEF,
   localparam int NW        = $clog2(NODE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic                  wr_kv_en,
   input  wire logic [NW-1:0]         wr_addr,
   input  wire logic [2*NW-1:0]       wr_link,
   input  wire logic [KEY_BITS-1:0]   wr_key,
   input  wire logic [VALUE_BITS-1:0] wr_val,
   input  wire logic [NW-1:0]         rd_addr,
   output logic      [2*NW-1:0]       rd_link,
   output logic      [KEY_BITS-1:0]   rd_key,
   output logic      [VALUE_BITS-1:0] rd_val
);

   logic [2*NW-1:0]       link_mem [NODE_DEPTH];
   logic [KEY_BITS-1:0]   key_mem  [NODE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem  [NODE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (wr_kv_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      rd_link <= link_mem[rd_addr];
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
   end

endmodule
`default_nettype wire

### hw/rtl/tbt_ctrl.sv
// trie walk sequencer: descent, nearest-leaf search, split, attach and the response register
`default_nettype none
module tbt_ctrl #(
   parameter int NODE_DEPTH = tbt_pkg::NODE_DEPTH_DEF,
   parameter int KEY_BITS   = tbt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = tbt_pkg::VALUE_BITS_DEF,
   localparam int NW        = $clog2(NODE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tbt_req_if.sink                    req,
   tbt_rsp_if.source                  rsp,
   output logic                       wr_en,
   output logic                       wr_kv_en,
   output logic      [NW-1:0]         wr_addr,
   output logic      [2*NW-1:0]       wr_link,
   output logic      [KEY_BITS-1:0]   wr_key,
   output logic      [VALUE_BITS-1:0] wr_val,
   output logic      [NW-1:0]         rd_addr,
   input  wire logic [2*NW-1:0]       rd_link,
   input  wire logic [KEY_BITS-1:0]   rd_key,
   input  wire logic [VALUE_BITS-1:0] rd_val
);

   localparam int CW = $clog2(NODE_DEPTH + 1);
   localparam int PW = $clog2(KEY_BITS);
   localparam int DW = $clog2(KEY_BITS + 2);
   localparam int SW = CW + 8;
   localparam int CNT_W = tbt_pkg::CNT_W;
   localparam int HGT_W = tbt_pkg::HGT_W;

   tbt_pkg::state_type  state_ff, state_in;
   tbt_pkg::status_type status_ff, status_in;

   logic                  type_ff, type_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [NW-1:0]         cur_ff, cur_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         p_ff, p_in;
   logic [PW-1:0]         q_ff, q_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [DW-1:0]         eq_ff, eq_in;
   logic [DW-1:0]         k_ff, k_in;
   logic                  pref_ff, pref_in;
   logic [2*NW-1:0]       links_ff, links_in;
   logic [KEY_BITS-1:0]   old_key_ff, old_key_in;
   logic [VALUE_BITS-1:0] old_val_ff, old_val_in;
   logic [KEY_BITS-1:0]   fkey_ff, fkey_in;
   logic [VALUE_BITS-1:0] fval_ff, fval_in;
   logic [CW-1:0]         nodes_ff, nodes_in;
   logic [CW-1:0]         keys_ff, keys_in;
   logic [DW-1:0]         height_ff, height_in;
   logic                  root_ff, root_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [tbt_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic [VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic [CNT_W-1:0]      rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]      rsp_int_ff, rsp_int_in;
   logic [HGT_W-1:0]      rsp_hgt_ff, rsp_hgt_in;

   // decoded view of the node just read
   logic [NW-1:0] lk0, lk1, ch, other, near_pick, near_alt, near_nx;
   logic          leaf, s_bit, key_match, scan_same, full_single, full_split;
   logic          out_free, last_link, split_end;
   logic [SW-1:0] need_sum, used_ext, split_used;
   logic [SW-1:0] addr_sum, tgt_sum;
   logic [NW-1:0] u_idx, a_idx, b_idx, tgt_idx;
   logic [2*NW-1:0] split_links;
   logic [DW-1:0] split_hgt;
   logic [CW+CNT_W-1:0] keys_wide, int_wide;
   logic [DW+HGT_W-1:0] hgt_wide;

   assign lk0       = rd_link[NW-1:0];
   assign lk1       = rd_link[2*NW-1:NW];
   assign leaf      = (rd_link == '0);
   assign s_bit     = key_ff[pos_ff];
   assign ch        = s_bit ? lk1 : lk0;
   assign other     = s_bit ? lk0 : lk1;
   assign near_pick = pref_ff ? lk1 : lk0;
   assign near_alt  = pref_ff ? lk0 : lk1;
   assign near_nx   = (near_pick != '0) ? near_pick : near_alt;
   assign key_match = (rd_key == key_ff);
   assign scan_same = (key_ff[p_ff] == old_key_ff[p_ff]);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign used_ext    = SW'(nodes_ff);
   assign need_sum    = used_ext + SW'(eq_ff) + SW'(2);
   assign full_split  = (need_sum > SW'(NODE_DEPTH));
   assign full_single = (nodes_ff >= CW'(NODE_DEPTH));
   assign split_used  = used_ext + SW'(eq_ff) + SW'(2);
   assign u_idx       = used_ext[NW-1:0];
   assign addr_sum    = used_ext + SW'(k_ff) - SW'(1);
   assign tgt_sum     = used_ext + SW'(k_ff);
   assign tgt_idx     = tgt_sum[NW-1:0];
   assign a_idx       = NW'(used_ext + SW'(eq_ff));
   assign b_idx       = NW'(used_ext + SW'(eq_ff) + SW'(1));
   assign split_links = key_ff[p_ff] ? {a_idx, b_idx} : {b_idx, a_idx};
   assign split_hgt   = depth_ff + eq_ff + DW'(1);
   assign last_link   = (k_ff == eq_ff);
   assign split_end   = (k_ff == eq_ff + DW'(2));

   assign keys_wide = {{CNT_W{1'b0}}, keys_ff};
   assign int_wide  = {{CNT_W{1'b0}}, CW'(nodes_ff - keys_ff)};
   assign hgt_wide  = {{HGT_W{1'b0}}, height_ff};

   assign req.ready          = (state_ff == tbt_pkg::ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.found_key      = rsp_key_ff;
   assign rsp.found_value    = rsp_val_ff;
   assign rsp.entry_count    = rsp_entry_ff;
   assign rsp.internal_count = rsp_int_ff;
   assign rsp.tree_height    = rsp_hgt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbt_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (!root_ff) begin
                  state_in = (req.req_type == tbt_pkg::REQ_SEARCH) ?
                             tbt_pkg::ST_DONE : tbt_pkg::ST_ROOT;
               end else begin
                  state_in = tbt_pkg::ST_WALK;
               end
            end
         end
         tbt_pkg::ST_ROOT: state_in = tbt_pkg::ST_DONE;
         tbt_pkg::ST_WALK: begin
            if (type_ff == tbt_pkg::REQ_INSERT) begin
               if (leaf) begin
                  state_in = key_match ? tbt_pkg::ST_DONE : tbt_pkg::ST_SCAN;
               end else if (ch == '0) begin
                  state_in = full_single ? tbt_pkg::ST_DONE : tbt_pkg::ST_ATTACH;
               end
            end else begin
               if (leaf) begin
                  state_in = tbt_pkg::ST_DONE;
               end else if (ch == '0) begin
                  state_in = tbt_pkg::ST_NEAR;
               end
            end
         end
         tbt_pkg::ST_NEAR: begin
            if (leaf) begin
               state_in = tbt_pkg::ST_DONE;
            end
         end
         tbt_pkg::ST_SCAN: begin
            if (!scan_same) begin
               state_in = full_split ? tbt_pkg::ST_DONE : tbt_pkg::ST_SPLIT;
            end
         end
         tbt_pkg::ST_SPLIT: begin
            if (split_end) begin
               state_in = tbt_pkg::ST_DONE;
            end
         end
         tbt_pkg::ST_ATTACH: begin
            if (k_ff != '0) begin
               state_in = tbt_pkg::ST_DONE;
            end
         end
         tbt_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = tbt_pkg::ST_IDLE;
            end
         end
         default: state_in = tbt_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      status_in   = status_ff;
      type_in     = type_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      cur_in      = cur_ff;
      pos_in      = pos_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      depth_in    = depth_ff;
      eq_in       = eq_ff;
      k_in        = k_ff;
      pref_in     = pref_ff;
      links_in    = links_ff;
      old_key_in  = old_key_ff;
      old_val_in  = old_val_ff;
      fkey_in     = fkey_ff;
      fval_in     = fval_ff;
      nodes_in    = nodes_ff;
      keys_in     = keys_ff;
      height_in   = height_ff;
      root_in     = root_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_int_in    = rsp_int_ff;
      rsp_hgt_in    = rsp_hgt_ff;
      rd_addr  = '0;
      wr_en    = 1'b0;
      wr_kv_en = 1'b0;
      wr_addr  = cur_ff;
      wr_link  = '0;
      wr_key   = '0;
      wr_val   = '0;

      unique case (state_ff)
         tbt_pkg::ST_IDLE: begin
            if (req.valid) begin
               type_in   = req.req_type;
               key_in    = req.key;
               value_in  = req.value;
               cur_in    = '0;
               pos_in    = PW'(KEY_BITS - 1);
               depth_in  = DW'(1);
               fkey_in   = '0;
               fval_in   = '0;
               status_in = tbt_pkg::STAT_EMPTY;
            end
         end
         tbt_pkg::ST_ROOT: begin
            wr_en     = 1'b1;
            wr_kv_en  = 1'b1;
            wr_addr   = '0;
            wr_key    = key_ff;
            wr_val    = value_ff;
            nodes_in  = CW'(1);
            keys_in   = CW'(1);
            height_in = DW'(1);
            root_in   = 1'b1;
            status_in = tbt_pkg::STAT_OK;
         end
         tbt_pkg::ST_WALK: begin
            if (leaf) begin
               if (type_ff == tbt_pkg::REQ_INSERT) begin
                  status_in  = tbt_pkg::STAT_DUP;
                  old_key_in = rd_key;
                  old_val_in = rd_val;
                  p_in       = pos_ff;
                  q_in       = pos_ff;
                  eq_in      = '0;
               end else begin
                  status_in = tbt_pkg::STAT_OK;
                  fkey_in   = rd_key;
                  fval_in   = rd_val;
               end
            end else if (ch == '0) begin
               if (type_ff == tbt_pkg::REQ_INSERT) begin
                  status_in = tbt_pkg::STAT_FULL;
                  depth_in  = depth_ff + DW'(1);
                  links_in  = rd_link;
                  k_in      = '0;
               end else begin
                  rd_addr = other;
                  pref_in = s_bit;
               end
            end else begin
               rd_addr  = ch;
               cur_in   = ch;
               pos_in   = pos_ff - PW'(1);
               depth_in = depth_ff + DW'(1);
            end
         end
         tbt_pkg::ST_NEAR: begin
            rd_addr = near_nx;
            if (leaf) begin
               status_in = tbt_pkg::STAT_OK;
               fkey_in   = rd_key;
               fval_in   = rd_val;
            end
         end
         tbt_pkg::ST_SCAN: begin
            status_in = tbt_pkg::STAT_FULL;
            k_in      = '0;
            if (scan_same) begin
               eq_in = eq_ff + DW'(1);
               p_in  = p_ff - PW'(1);
            end
         end
         tbt_pkg::ST_SPLIT: begin
            wr_en   = 1'b1;
            k_in    = k_ff + DW'(1);
            wr_addr = (k_ff == '0) ? cur_ff : addr_sum[NW-1:0];
            if (k_ff <= eq_ff) begin
               wr_kv_en = (k_ff != '0);
               if (last_link) begin
                  wr_link = split_links;
               end else begin
                  wr_link = key_ff[q_ff] ? {tgt_idx, {NW{1'b0}}} : {{NW{1'b0}}, tgt_idx};
                  q_in    = q_ff - PW'(1);
               end
            end else if (!split_end) begin
               wr_kv_en = 1'b1;
               wr_key   = key_ff;
               wr_val   = value_ff;
            end else begin
               wr_kv_en  = 1'b1;
               wr_key    = old_key_ff;
               wr_val    = old_val_ff;
               nodes_in  = split_used[CW-1:0];
               keys_in   = keys_ff + CW'(1);
               height_in = (split_hgt > height_ff) ? split_hgt : height_ff;
               status_in = tbt_pkg::STAT_OK;
            end
         end
         tbt_pkg::ST_ATTACH: begin
            wr_en = 1'b1;
            k_in  = k_ff + DW'(1);
            if (k_ff == '0) begin
               wr_kv_en = 1'b1;
               wr_addr  = u_idx;
               wr_key   = key_ff;
               wr_val   = value_ff;
            end else begin
               wr_addr   = cur_ff;
               wr_link   = s_bit ? {u_idx, links_ff[NW-1:0]} : {links_ff[2*NW-1:NW], u_idx};
               nodes_in  = nodes_ff + CW'(1);
               keys_in   = keys_ff + CW'(1);
               height_in = (depth_ff > height_ff) ? depth_ff : height_ff;
               status_in = tbt_pkg::STAT_OK;
            end
         end
         tbt_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_key_in    = fkey_ff;
               rsp_val_in    = fval_ff;
               rsp_entry_in  = keys_wide[CNT_W-1:0];
               rsp_int_in    = int_wide[CNT_W-1:0];
               rsp_hgt_in    = hgt_wide[HGT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbt_pkg::ST_IDLE;
         nodes_ff     <= '0;
         keys_ff      <= '0;
         height_ff    <= '0;
         root_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nodes_ff     <= nodes_in;
         keys_ff      <= keys_in;
         height_ff    <= height_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      type_ff       <= type_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      depth_ff      <= depth_in;
      eq_ff         <= eq_in;
      k_ff          <= k_in;
      pref_ff       <= pref_in;
      links_ff      <= links_in;
      old_key_ff    <= old_key_in;
      old_val_ff    <= old_val_in;
      fkey_ff       <= fkey_in;
      fval_ff       <= fval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_int_ff    <= rsp_int_in;
      rsp_hgt_ff    <= rsp_hgt_in;
   end

endmodule
`default_nettype wire

### hw/rtl/binary_trie_closest_key_lookup_top.sv
// Closest-key binary trie over KEY_BITS-bit keys, walked from the top key bit.
// req_bus carries one item per request: req_type (insert or search), key and
// value; rsp_bus returns exactly one item per request with status, the found
// key and value (search only) and the entry count, internal node count and
// height after the request. Both channels move an item when valid and ready
// are high at a rising clock edge.
// One request is worked at a time; req_bus.ready is high only while idle.
// All nodes sit in a single node memory with one read and one write port, so
// the trie is walked one level per cycle. An insert that splits a leaf scans
// the matching key bits to find the split point, then makes one memory write
// per new node plus one that turns the old leaf into an internal node.
// The response sits in an output register; a finished request waits there
// while rsp_bus is stalled, and the block takes the next request meanwhile.
// Synchronous reset empties the trie at once (no clearing pass is needed,
// every node is written when allocated) and drops any pending response.
`default_nettype none
module binary_trie_closest_key_lookup_top #(
   parameter int NODE_DEPTH = tbt_pkg::NODE_DEPTH_DEF,
   parameter int KEY_BITS   = tbt_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = tbt_pkg::VALUE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   tbt_req_if.sink   req_bus,
   tbt_rsp_if.source rsp_bus
);

   localparam int NW = $clog2(NODE_DEPTH);

   logic                  wr_en;
   logic                  wr_kv_en;
   logic [NW-1:0]         wr_addr;
   logic [2*NW-1:0]       wr_link;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;
   logic [NW-1:0]         rd_addr;
   logic [2*NW-1:0]       rd_link;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   tbt_ctrl #(
      .NODE_DEPTH (NODE_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .wr_en    (wr_en),
      .wr_kv_en (wr_kv_en),
      .wr_addr  (wr_addr),
      .wr_link  (wr_link),
      .wr_key   (wr_key),
      .wr_val   (wr_val),
      .rd_addr  (rd_addr),
      .rd_link  (rd_link),
      .rd_key   (rd_key),
      .rd_val   (rd_val)
   );

   tbt_mem #(
      .NODE_DEPTH (NODE_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_kv_en (wr_kv_en),
      .wr_addr  (wr_addr),
      .wr_link  (wr_link),
      .wr_key   (wr_key),
      .wr_val   (wr_val),
      .rd_addr  (rd_addr),
      .rd_link  (rd_link),
      .rd_key   (rd_key),
      .rd_val   (rd_val)
   );

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while another is in flight");

   // no response right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response present right after reset");

   // an empty trie holds no entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == tbt_pkg::STAT_EMPTY |->
         rsp_bus.entry_count == '0 && rsp_bus.found_key == '0)
      else $error("empty status with entries present");

   // a rejected insert returns no found data
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == tbt_pkg::STAT_FULL ||
                        rsp_bus.status == tbt_pkg::STAT_DUP) |->
         rsp_bus.found_key == '0 && rsp_bus.found_value == '0)
      else $error("rejected insert carries found data");

endmodule
`default_nettype wire
